// ===== design/mgst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgst_pkg
// Shared types and codes for the material grouping segment table.
// ----------------------------------------------------------------------------
package mgst_pkg;

    localparam int MaxSegmentsDefault = 32;

    localparam logic [2:0] KIND_ADD     = 3'd0;
    localparam logic [2:0] KIND_REORDER = 3'd1;
    localparam logic [2:0] KIND_FETCH   = 3'd2;
    localparam logic [2:0] KIND_MARK    = 3'd3;
    localparam logic [2:0] KIND_READ    = 3'd4;
    localparam logic [2:0] KIND_CLEAR   = 3'd5;
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_FEW     = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;

    localparam logic [1:0] STRAT_NONE   = 2'd0;
    localparam logic [1:0] STRAT_SORT   = 2'd1;
    localparam logic [1:0] STRAT_GREEDY = 2'd2;
    localparam logic [1:0] STRAT_HEAT   = 2'd3;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  mat;
        logic [15:0] len;
        logic [6:0]  origin;
        logic        done;
    } seg_t;

endpackage

// ===== design/material_grouping_segment_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// material_grouping_segment_table
// Segment table with add, reorder, fetch, mark, read and clear commands.
// ----------------------------------------------------------------------------
// channel   direction  handshake
// command   in         start & !busy
// result    out        done strobe, one cycle
// Every command rescans the table for live material changes before done.
// Fetch scans slots from the cursor for one not yet marked done.
// Reorder makes four scans (before, after, moved, live) plus, unless the
// strategy is none, the sort or greedy pass through the memory's one read
// and one write port. Reset clears counts; the store is undefined until
// written. The receiver cannot stall; done is a single-cycle strobe.
module material_grouping_segment_table
    import mgst_pkg::*;
#(
    parameter int MAX_SEGMENTS = MaxSegmentsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [15:0] segment_id,
    input  logic [7:0]  material_code,
    input  logic [15:0] length_mm,
    input  logic [1:0]  strategy,
    input  logic [4:0]  slot,
    output logic        done,
    output logic [2:0]  status,
    output logic [4:0]  entry_slot,
    output logic [15:0] entry_id,
    output logic [7:0]  entry_material,
    output logic [15:0] entry_length,
    output logic [4:0]  entry_origin,
    output logic        entry_done,
    output logic [5:0]  entry_count,
    output logic [5:0]  moved_count,
    output logic [4:0]  changes_before,
    output logic [4:0]  changes_after,
    output logic [4:0]  live_changes
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = AW + 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD    = 11'b00000000010,
        S_FETCH = 11'b00000000100,
        S_CNT   = 11'b00000001000,
        S_OUTER = 11'b00000010000,
        S_INNER = 11'b00000100000,
        S_SHIFT = 11'b00001000000,
        S_PUT   = 11'b00010000000,
        S_MOVED = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_WAIT  = 11'b10000000000
    } state_t;

    // count phase: 0 before, 1 after, 2 live
    state_t       state_reg, state_next;
    seg_t         mem [MAX_SEGMENTS];
    seg_t         rdata_reg;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    seg_t          wdata;

    logic [CW-1:0] held_reg, held_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] moved_reg, moved_next;
    logic [4:0]    cb_reg, cb_next, ca_reg, ca_next, live_reg, live_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    phase_reg, phase_next;
    logic [7:0]    prev_reg, prev_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    seg_t          key_reg, key_next;
    logic [7:0]    curm_reg, curm_next;
    logic [1:0]    sub_reg, sub_next;
    logic [2:0]    kind_reg, kind_next;
    logic [1:0]    strat_reg, strat_next;
    logic [2:0]    st_reg, st_next;
    logic          have_reg, have_next;
    logic [CW-1:0] where_reg, where_next;
    logic          done_reg, done_next;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    function automatic logic [4:0] sat5(input logic [CW-1:0] v);
        logic [CW:0] w;
        begin
            w = {1'b0, v};
            sat5 = (w > (CW+1)'(31)) ? 5'd31 : w[4:0];
        end
    endfunction

    always_comb
    begin
        state_next = state_reg;
        held_next = held_reg; cur_next = cur_reg; moved_next = moved_reg;
        cb_next = cb_reg; ca_next = ca_reg; live_next = live_reg;
        cnt_next = cnt_reg; phase_next = phase_reg; prev_next = prev_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg; key_next = key_reg;
        curm_next = curm_reg; sub_next = sub_reg; kind_next = kind_reg;
        strat_next = strat_reg; st_next = st_reg; have_next = have_reg;
        where_next = where_reg; done_next = 1'b0;
        raddr = '0; we = 1'b0; waddr = '0; wdata = rdata_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind; strat_next = strategy;
                    st_next = ST_OK; have_next = 1'b0; where_next = '0;
                    case (kind)
                        KIND_ADD:
                        begin
                            if (held_reg >= CW'(MAX_SEGMENTS))
                            begin
                                st_next = ST_FULL;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                we = 1'b1; waddr = held_reg[AW-1:0];
                                wdata = '{segment_id, material_code, length_mm,
                                          7'(held_reg), 1'b0};
                                where_next = held_reg;
                                have_next = 1'b1;
                                held_next = held_reg + 1'b1;
                                state_next = S_RD;
                            end
                        end
                        KIND_REORDER:
                        begin
                            if (held_reg < CW'(2))
                            begin
                                st_next = ST_FEW;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                phase_next = 2'd0; cnt_next = '0;
                                i_next = '0; sub_next = 2'd0;
                                state_next = S_CNT;
                            end
                        end
                        KIND_FETCH:
                        begin
                            st_next = ST_NONE; i_next = cur_reg;
                            sub_next = 2'd0; state_next = S_FETCH;
                        end
                        KIND_MARK, KIND_READ:
                        begin
                            if ({1'b0, slot} >= (CW+1)'(held_reg))
                            begin
                                st_next = ST_RANGE;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                where_next = CW'(slot); have_next = 1'b1;
                                raddr = AW'(slot);
                                state_next = S_RD;
                                sub_next = (kind == KIND_MARK) ? 2'd1 : 2'd0;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            held_next = '0; cur_next = '0; moved_next = '0;
                            cb_next = '0; ca_next = '0; live_next = '0;
                            state_next = S_EMIT;
                        end
                        default: state_next = S_EMIT;
                    endcase
                end
            end
            S_RD:
            begin
                raddr = where_reg[AW-1:0];
                if (sub_reg == 2'd1)
                begin
                    sub_next = 2'd2;
                end
                else if (sub_reg == 2'd2)
                begin
                    we = 1'b1; waddr = where_reg[AW-1:0];
                    wdata = rdata_reg; wdata.done = 1'b1;
                    cur_next = where_reg + 1'b1;
                    sub_next = 2'd0;
                end
                else
                begin
                    sub_next = 2'd3;
                    if (sub_reg == 2'd3)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_FETCH:
            begin
                raddr = i_reg[AW-1:0];
                if (sub_reg == 2'd0)
                begin
                    if (i_reg >= held_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sub_next = 2'd1;
                    end
                end
                else if (!rdata_reg.done)
                begin
                    cur_next = i_reg; where_next = i_reg; have_next = 1'b1;
                    st_next = ST_OK; state_next = S_EMIT;
                end
                else
                begin
                    i_next = i_reg + 1'b1; sub_next = 2'd0;
                end
            end
            S_CNT:
            begin
                raddr = i_reg[AW-1:0];
                if (sub_reg == 2'd0)
                begin
                    if (i_reg >= held_reg)
                    begin
                        case (phase_reg)
                            2'd0:
                            begin
                                cb_next = sat5(cnt_reg);
                                i_next = '0; sub_next = 2'd0;
                                if (strat_reg == STRAT_NONE)
                                begin
                                    phase_next = 2'd1; cnt_next = '0;
                                end
                                else
                                begin
                                    j_next = CW'(1); state_next = S_OUTER;
                                end
                            end
                            2'd1:
                            begin
                                ca_next = sat5(cnt_reg);
                                i_next = '0; moved_next = '0;
                                state_next = S_MOVED;
                            end
                            default:
                            begin
                                live_next = sat5(cnt_reg);
                                state_next = S_EMIT;
                            end
                        endcase
                    end
                    else
                    begin
                        sub_next = 2'd1;
                    end
                end
                else
                begin
                    if (i_reg != '0 && rdata_reg.mat != prev_reg
                        && cnt_reg != CW'(31))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    prev_next = rdata_reg.mat;
                    i_next = i_reg + 1'b1; sub_next = 2'd0;
                end
            end
            S_OUTER:
            begin
                // sort: j is the insertion index; greedy: i is the anchor
                if (strat_reg == STRAT_SORT)
                begin
                    raddr = j_reg[AW-1:0];
                    if (sub_reg == 2'd0)
                    begin
                        if (j_reg >= held_reg)
                        begin
                            phase_next = 2'd1; cnt_next = '0; i_next = '0;
                            state_next = S_CNT;
                        end
                        else
                        begin
                            sub_next = 2'd1;
                        end
                    end
                    else
                    begin
                        key_next = rdata_reg; k_next = j_reg;
                        sub_next = 2'd0; state_next = S_SHIFT;
                    end
                end
                else
                begin
                    raddr = i_reg[AW-1:0];
                    if (sub_reg == 2'd0)
                    begin
                        if (i_reg >= held_reg)
                        begin
                            phase_next = 2'd1; cnt_next = '0; i_next = '0;
                            state_next = S_CNT;
                        end
                        else
                        begin
                            sub_next = 2'd1;
                        end
                    end
                    else
                    begin
                        curm_next = rdata_reg.mat; j_next = i_reg + 1'b1;
                        sub_next = 2'd0; state_next = S_INNER;
                    end
                end
            end
            S_INNER:
            begin
                raddr = j_reg[AW-1:0];
                if (sub_reg == 2'd0)
                begin
                    if (j_reg >= held_reg)
                    begin
                        i_next = i_reg + 1'b1; state_next = S_OUTER;
                    end
                    else
                    begin
                        sub_next = 2'd1;
                    end
                end
                else if (rdata_reg.mat == curm_reg)
                begin
                    key_next = rdata_reg; k_next = j_reg;
                    sub_next = 2'd0; state_next = S_SHIFT;
                end
                else
                begin
                    j_next = j_reg + 1'b1; sub_next = 2'd0;
                end
            end
            S_SHIFT:
            begin
                // move entry k-1 up to k while condition holds
                raddr = k_reg[AW-1:0] - 1'b1;
                if (sub_reg == 2'd0)
                begin
                    if (strat_reg == STRAT_SORT ? (k_reg == '0)
                                                : (k_reg <= i_reg + 1'b1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        sub_next = 2'd1;
                    end
                end
                else if (strat_reg == STRAT_SORT && !(rdata_reg.mat > key_reg.mat))
                begin
                    sub_next = 2'd0; state_next = S_PUT;
                end
                else
                begin
                    we = 1'b1; waddr = k_reg[AW-1:0]; wdata = rdata_reg;
                    k_next = k_reg - 1'b1; sub_next = 2'd0;
                end
            end
            S_PUT:
            begin
                we = 1'b1; waddr = k_reg[AW-1:0]; wdata = key_reg;
                if (strat_reg == STRAT_SORT)
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_OUTER;
                end
                else
                begin
                    i_next = i_reg + 1'b1; j_next = j_reg + 1'b1;
                    state_next = S_INNER;
                end
            end
            S_MOVED:
            begin
                raddr = i_reg[AW-1:0];
                if (sub_reg == 2'd0)
                begin
                    if (i_reg >= held_reg)
                    begin
                        phase_next = 2'd2; cnt_next = '0; i_next = '0;
                        state_next = S_CNT;
                    end
                    else
                    begin
                        sub_next = 2'd1;
                    end
                end
                else
                begin
                    if (rdata_reg.origin != 7'(i_reg))
                    begin
                        moved_next = moved_reg + 1'b1;
                    end
                    i_next = i_reg + 1'b1; sub_next = 2'd0;
                end
            end
            S_EMIT:
            begin
                if (kind_reg == KIND_REORDER && st_reg == ST_OK)
                begin
                    done_next = 1'b1; state_next = S_WAIT;
                end
                else
                begin
                    phase_next = 2'd2; cnt_next = '0; i_next = '0;
                    sub_next = 2'd0; kind_next = KIND_REORDER;
                    st_next = (st_reg == ST_OK) ? ST_OK : st_reg;
                    state_next = S_CNT;
                    // live count then emit
                    if (phase_reg == 2'd2 && i_reg >= held_reg)
                    begin
                        done_next = 1'b1; state_next = S_WAIT;
                    end
                end
                raddr = where_reg[AW-1:0];
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
                phase_next = 2'd0;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // hold the entry read for the result
    seg_t ent_reg;
    logic emit_mark;
    assign emit_mark = (state_reg == S_RD && sub_reg == 2'd3) ||
                       (state_reg == S_FETCH && sub_reg == 2'd1 && !rdata_reg.done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg <= '0; cur_reg <= '0; moved_reg <= '0;
            cb_reg <= '0; ca_reg <= '0; live_reg <= '0;
            done_reg <= 1'b0; phase_reg <= 2'd0; sub_reg <= 2'd0;
            kind_reg <= KIND_CLEAR; st_reg <= ST_OK; have_reg <= 1'b0;
            i_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg <= held_next; cur_reg <= cur_next; moved_reg <= moved_next;
            cb_reg <= cb_next; ca_reg <= ca_next; live_reg <= live_next;
            done_reg <= done_next; phase_reg <= phase_next; sub_reg <= sub_next;
            kind_reg <= kind_next; st_reg <= st_next; have_reg <= have_next;
            i_reg <= i_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next; j_reg <= j_next; k_reg <= k_next;
        key_reg <= key_next; curm_reg <= curm_next; strat_reg <= strat_next;
        where_reg <= where_next;
        if (emit_mark)
        begin
            ent_reg <= rdata_reg;
        end
    end

    logic [5:0] held6, moved6;
    assign held6  = (CW > 6 && held_reg > CW'(63)) ? 6'd63 : 6'(held_reg);
    assign moved6 = (CW > 6 && moved_reg > CW'(63)) ? 6'd63 : 6'(moved_reg);

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = st_reg;
    assign entry_slot     = have_reg ? sat5(where_reg) : 5'd0;
    assign entry_id       = have_reg ? ent_reg.id : 16'd0;
    assign entry_material = have_reg ? ent_reg.mat : 8'd0;
    assign entry_length   = have_reg ? ent_reg.len : 16'd0;
    assign entry_origin   = have_reg ? ((ent_reg.origin > 7'd31) ? 5'd31
                                                                 : ent_reg.origin[4:0])
                                     : 5'd0;
    assign entry_done     = have_reg ? ent_reg.done : 1'b0;
    assign entry_count    = held6;
    assign moved_count    = moved6;
    assign changes_before = cb_reg;
    assign changes_after  = ca_reg;
    assign live_changes   = live_reg;

endmodule

// ===== bench/material_grouping_segment_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// material_grouping_segment_table_checker
// Watches the command and result channels of the segment table, keeps its own
// copy of the table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module material_grouping_segment_table_checker
    import mgst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  kind,
    input  logic [15:0] segment_id,
    input  logic [7:0]  material_code,
    input  logic [15:0] length_mm,
    input  logic [1:0]  strategy,
    input  logic [4:0]  slot,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [4:0]  entry_slot,
    input  logic [15:0] entry_id,
    input  logic [7:0]  entry_material,
    input  logic [15:0] entry_length,
    input  logic [4:0]  entry_origin,
    input  logic        entry_done,
    input  logic [5:0]  entry_count,
    input  logic [5:0]  moved_count,
    input  logic [4:0]  changes_before,
    input  logic [4:0]  changes_after,
    input  logic [4:0]  live_changes,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [15:0] id;
        logic [7:0]  mat;
        logic [15:0] len;
        int          origin;
        logic        fin;
    } segment_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  eslot;
        logic [15:0] id;
        logic [7:0]  mat;
        logic [15:0] len;
        logic [4:0]  origin;
        logic        fin;
        logic [5:0]  count;
        logic [5:0]  moved;
        logic [4:0]  prior;
        logic [4:0]  later;
        logic [4:0]  live;
    } result_t;

    segment_t table_q[MaxSegmentsDefault];
    int       held;
    int       cursor;
    int       moved_r;
    int       before_r;
    int       after_r;
    result_t  expected_q[$];

    function automatic int material_changes();
        int n;
        n = 0;
        for (int i = 1; i < held; i++)
            if (table_q[i].mat != table_q[i - 1].mat)
                n++;
        return n;
    endfunction

    function automatic logic [4:0] sat5(int v);
        return (v > 31) ? 5'd31 : v[4:0];
    endfunction

    task automatic apply_command(logic [2:0] k, logic [15:0] sid, logic [7:0] mc,
                                 logic [15:0] ln, logic [1:0] st, logic [4:0] sl);
        result_t  r;
        segment_t t;
        logic     have;
        int       where;
        int       j;
        r = '0;
        have = 0;
        where = 0;
        case (k)
            KIND_ADD: begin
                if (held >= MaxSegmentsDefault) begin
                    r.status = ST_FULL;
                end
                else begin
                    table_q[held] = '{sid, mc, ln, held, 1'b0};
                    where = held;
                    have = 1;
                    held++;
                end
            end
            KIND_REORDER: begin
                if (held < 2) begin
                    r.status = ST_FEW;
                end
                else begin
                    before_r = material_changes();
                    if (st == STRAT_SORT) begin
                        for (int i = 1; i < held; i++) begin
                            t = table_q[i];
                            j = i;
                            while (j > 0 && table_q[j - 1].mat > t.mat) begin
                                table_q[j] = table_q[j - 1];
                                j--;
                            end
                            table_q[j] = t;
                        end
                    end
                    else if (st != STRAT_NONE) begin
                        for (int i = 0; i < held; i++) begin
                            logic [7:0] cur;
                            cur = table_q[i].mat;
                            for (int m = i + 1; m < held; m++) begin
                                if (table_q[m].mat == cur) begin
                                    t = table_q[m];
                                    for (int p = m; p > i + 1; p--)
                                        table_q[p] = table_q[p - 1];
                                    table_q[i + 1] = t;
                                    i++;
                                end
                            end
                        end
                    end
                    after_r = material_changes();
                    moved_r = 0;
                    for (int i = 0; i < held; i++)
                        if (table_q[i].origin != i)
                            moved_r++;
                end
            end
            KIND_FETCH: begin
                r.status = ST_NONE;
                for (int i = cursor; i < held; i++) begin
                    if (!table_q[i].fin) begin
                        cursor = i;
                        where = i;
                        have = 1;
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            KIND_MARK: begin
                if (sl >= held) begin
                    r.status = ST_RANGE;
                end
                else begin
                    table_q[sl].fin = 1;
                    cursor = sl + 1;
                    where = sl;
                    have = 1;
                end
            end
            KIND_READ: begin
                if (sl >= held) begin
                    r.status = ST_RANGE;
                end
                else begin
                    where = sl;
                    have = 1;
                end
            end
            KIND_CLEAR: begin
                held = 0;
                cursor = 0;
                moved_r = 0;
                before_r = 0;
                after_r = 0;
            end
            default: ;
        endcase
        if (have) begin
            r.eslot = sat5(where);
            r.id = table_q[where].id;
            r.mat = table_q[where].mat;
            r.len = table_q[where].len;
            r.origin = sat5(table_q[where].origin);
            r.fin = table_q[where].fin;
        end
        r.count = held[5:0];
        r.moved = moved_r[5:0];
        r.prior = sat5(before_r);
        r.later = sat5(after_r);
        r.live = sat5(material_changes());
        expected_q.push_back(r);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        held = 0;
        cursor = 0;
        moved_r = 0;
        before_r = 0;
        after_r = 0;
    end

    assign pending = expected_q.size();

    always @(posedge clk) begin
        result_t e;
        if (rst_n) begin
            if (done) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("results waiting", 1, 0);
                end
                else begin
                    e = expected_q.pop_front();
                    if (status != e.status) report_mismatch("status", status, e.status);
                    if (entry_slot != e.eslot) report_mismatch("entry_slot", entry_slot, e.eslot);
                    if (entry_id != e.id) report_mismatch("entry_id", entry_id, e.id);
                    if (entry_material != e.mat)
                        report_mismatch("entry_material", entry_material, e.mat);
                    if (entry_length != e.len)
                        report_mismatch("entry_length", entry_length, e.len);
                    if (entry_origin != e.origin)
                        report_mismatch("entry_origin", entry_origin, e.origin);
                    if (entry_done != e.fin) report_mismatch("entry_done", entry_done, e.fin);
                    if (entry_count != e.count)
                        report_mismatch("entry_count", entry_count, e.count);
                    if (moved_count != e.moved)
                        report_mismatch("moved_count", moved_count, e.moved);
                    if (changes_before != e.prior)
                        report_mismatch("changes_before", changes_before, e.prior);
                    if (changes_after != e.later)
                        report_mismatch("changes_after", changes_after, e.later);
                    if (live_changes != e.live)
                        report_mismatch("live_changes", live_changes, e.live);
                end
            end
            if (start && !busy)
                apply_command(kind, segment_id, material_code, length_mm, strategy, slot);
        end
    end

endmodule

// ===== bench/material_grouping_segment_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// material_grouping_segment_table_test
// Drives directed and random command sequences into the segment table: table
// fills with reorders of every strategy, fetch and mark walks, reads, clears.
// ----------------------------------------------------------------------------
module material_grouping_segment_table_test;
    import mgst_pkg::*;

    localparam int Limit = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  kind;
    logic [15:0] segment_id;
    logic [7:0]  material_code;
    logic [15:0] length_mm;
    logic [1:0]  strategy;
    logic [4:0]  slot;
    logic        done;
    logic [2:0]  status;
    logic [4:0]  entry_slot;
    logic [15:0] entry_id;
    logic [7:0]  entry_material;
    logic [15:0] entry_length;
    logic [4:0]  entry_origin;
    logic        entry_done;
    logic [5:0]  entry_count;
    logic [5:0]  moved_count;
    logic [4:0]  changes_before;
    logic [4:0]  changes_after;
    logic [4:0]  live_changes;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          sent;
    int          tail_start;
    bit          drained;

    material_grouping_segment_table dut (.*);
    material_grouping_segment_table_checker checker_i (.*);

    initial clk = 0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= Limit) begin
            $display("material_grouping_segment_table test failed");
            $finish;
        end
    end

    task automatic send(logic [2:0] k, logic [15:0] sid, logic [7:0] mc,
                        logic [15:0] ln, logic [1:0] st, logic [4:0] sl);
        if (sent < tail_start && $urandom_range(0, 3) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        start <= 1;
        kind <= k;
        segment_id <= sid;
        material_code <= mc;
        length_mm <= ln;
        strategy <= st;
        slot <= sl;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic random_command(int mat_span);
        int          r;
        logic [15:0] sid;
        logic [15:0] ln;
        logic [7:0]  mc;
        logic [1:0]  st;
        logic [4:0]  sl;
        r = $urandom_range(0, 99);
        sid = 16'($urandom);
        ln = 16'($urandom);
        mc = 8'($urandom);
        st = 2'($urandom);
        sl = 5'($urandom);
        if (r < 45)
            send(KIND_ADD, sid, 8'($urandom_range(0, mat_span)), ln, st, sl);
        else if (r < 53)
            send(KIND_REORDER, sid, mc, ln, st, sl);
        else if (r < 68)
            send(KIND_FETCH, sid, mc, ln, st, sl);
        else if (r < 80)
            send(KIND_MARK, sid, mc, ln, st, sl);
        else if (r < 93)
            send(KIND_READ, sid, mc, ln, st, sl);
        else if (r < 97)
            send(KIND_CLEAR, sid, mc, ln, st, sl);
        else
            send(($urandom_range(0, 1) != 0) ? KIND_SPARE_B : KIND_SPARE_A,
                 sid, mc, ln, st, sl);
    endtask

    initial begin
        int mat_span;
        rst_n = 0;
        start = 0;
        kind = KIND_ADD;
        segment_id = 0;
        material_code = 0;
        length_mm = 0;
        strategy = STRAT_NONE;
        slot = 0;
        sent = 0;
        tail_start = 1500;
        drained = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send(KIND_REORDER, 0, 0, 0, STRAT_SORT, 0);
        send(KIND_FETCH, 0, 0, 0, 0, 0);
        send(KIND_READ, 0, 0, 0, 0, 0);
        send(KIND_MARK, 0, 0, 0, 0, 31);
        send(KIND_ADD, 16'hFFFF, 8'hFF, 16'hFFFF, STRAT_HEAT, 5'd31);
        send(KIND_REORDER, 0, 0, 0, STRAT_SORT, 0);
        send(KIND_ADD, 0, 0, 0, 0, 0);
        send(KIND_ADD, 16'h1234, 8'hFF, 16'h0001, 0, 0);
        send(KIND_REORDER, 0, 0, 0, STRAT_NONE, 0);
        send(KIND_REORDER, 0, 0, 0, STRAT_SORT, 0);
        send(KIND_REORDER, 0, 0, 0, STRAT_GREEDY, 0);
        send(KIND_REORDER, 0, 0, 0, STRAT_HEAT, 0);
        send(KIND_MARK, 0, 0, 0, 0, 1);
        send(KIND_FETCH, 0, 0, 0, 0, 0);
        send(KIND_READ, 0, 0, 0, 0, 2);
        send(KIND_READ, 0, 0, 0, 0, 3);
        send(KIND_SPARE_A, 0, 0, 0, 0, 0);
        send(KIND_SPARE_B, 0, 0, 0, 0, 0);
        for (int i = 0; i < 31; i++)
            send(KIND_ADD, 16'($urandom), 8'($urandom_range(0, 3)), 16'($urandom),
                 STRAT_NONE, 5'd0);
        send(KIND_REORDER, 0, 0, 0, STRAT_SORT, 0);
        send(KIND_READ, 0, 0, 0, 0, 31);
        send(KIND_CLEAR, 0, 0, 0, 0, 0);

        while (sent < 1650) begin
            mat_span = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 5);
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(2, 34))
                    send(KIND_ADD, 16'($urandom), 8'($urandom_range(0, mat_span)),
                         16'($urandom), STRAT_NONE, 5'd0);
                send(KIND_REORDER, 0, 0, 0, 2'($urandom), 0);
                repeat ($urandom_range(0, 12)) begin
                    if ($urandom_range(0, 1))
                        send(KIND_FETCH, 0, 0, 0, 0, 0);
                    else
                        send(KIND_MARK, 0, 0, 0, 0, 5'($urandom));
                end
            end
            repeat ($urandom_range(3, 25)) random_command(mat_span);
            if (!drained && sent > 800) begin
                drained = 1;
                start <= 0;
                while (pending != 0) @(negedge clk);
            end
        end
        start <= 0;
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("material_grouping_segment_table test passed");
        else
            $display("material_grouping_segment_table test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mgst_pkg.sv
design/material_grouping_segment_table.sv
bench/material_grouping_segment_table_checker.sv
bench/material_grouping_segment_table_test.sv
